>>> rtl/prefix_table_fifo_evict_unit_macros.svh
// Assertion macros used by the prefix table RTL.
`ifndef PREFIX_TABLE_FIFO_EVICT_UNIT_MACROS_SVH
`define PREFIX_TABLE_FIFO_EVICT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pte_pkg.sv
`timescale 1ns / 1ps

package pte_pkg;

	localparam int PTE_TABLE_ENTRIES = 8;
	localparam int PTE_COUNT_OUT_W = 7;

	typedef enum logic [1:0] {
		ST_ADDED     = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ADD    = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic        req_type;
		logic [63:0] prefix_key;
		logic [7:0]  dom_id;
		logic [15:0] border_router;
		logic        stable;
		logic        auto_pref;
		logic        auto_valid;
		logic        dhcp;
		logic        configure;
		logic        default_route;
		logic        preference;
	} req_t;

	typedef struct packed {
		status_t                      status;
		logic                         evicted;
		logic [PTE_COUNT_OUT_W-1:0]   entry_count_out;
		logic [7:0]                   found_dom_id;
		logic [15:0]                  found_border_router;
		logic                         found_stable;
		logic                         found_auto_pref;
		logic                         found_auto_valid;
		logic                         found_dhcp;
		logic                         found_configure;
		logic                         found_default_route;
		logic                         found_preference;
	} rsp_t;

	typedef struct packed {
		logic [15:0] border_router;
		logic [7:0]  dom_id;
		logic        preference;
		logic        default_route;
		logic        configure;
		logic        dhcp;
		logic        auto_valid;
		logic        auto_pref;
		logic        stable;
	} attr_t;

	typedef struct packed {
		logic        en;
		logic [63:0] key;
		attr_t       attr;
	} wr_t;

	function automatic attr_t req_to_attr(req_t r);
		attr_t a;
		a.border_router = r.border_router;
		a.dom_id        = r.dom_id;
		a.preference    = r.preference;
		a.default_route = r.default_route;
		a.configure     = r.configure;
		a.dhcp          = r.dhcp;
		a.auto_valid    = r.auto_valid;
		a.auto_pref     = r.auto_pref;
		a.stable        = r.stable;
		return a;
	endfunction

endpackage

>>> rtl/pte_if.sv
`timescale 1ns / 1ps

interface pte_req_if;
	import pte_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pte_rsp_if;
	import pte_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pte_store.sv
`timescale 1ns / 1ps

module pte_store #(
	parameter int TABLE_ENTRIES = pte_pkg::PTE_TABLE_ENTRIES,
	parameter int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                clk,
	input  pte_pkg::wr_t        wr,
	input  logic [SLOT_W-1:0]   wr_addr,
	input  logic [SLOT_W-1:0]   rd_addr,
	output logic [63:0]         rd_key,
	output pte_pkg::attr_t      rd_attr
);
	import pte_pkg::*;

	logic [63:0] key_mem [TABLE_ENTRIES];
	attr_t       attr_mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr_addr]  <= wr.key;
			attr_mem[wr_addr] <= wr.attr;
		end
	end

	always_ff @(posedge clk) begin
		rd_key  <= key_mem[rd_addr];
		rd_attr <= attr_mem[rd_addr];
	end

endmodule

>>> rtl/prefix_table_fifo_evict_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// req      in   one add or lookup request (req_t)
// rsp      out  one result per request (rsp_t)
//
// A request is accepted in S_IDLE; S_SCAN then reads the stored keys from the key
// memory, newest first, and compares each registered read key with the request key;
// S_FIN writes the memory for a new add and loads the result register once it is free.
// With a full table all TABLE_ENTRIES keys are scanned; a hit ends the scan early.
// arst_n clears the fill count and the newest-slot pointer; memory is not cleared.
// A stalled result holds in its register while the next request is scanned.
`include "prefix_table_fifo_evict_unit_macros.svh"

module prefix_table_fifo_evict_unit #(
	parameter int TABLE_ENTRIES = pte_pkg::PTE_TABLE_ENTRIES
) (
	input logic     clk,
	input logic     arst_n,
	pte_req_if.sink req,
	pte_rsp_if.source rsp
);
	import pte_pkg::*;

	localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} fsm_t;

	fsm_t              state_q;
	logic [SLOT_W-1:0] newest_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] scan_slot_q;
	logic [CNT_W-1:0]  left_q;
	logic              vld_s1;
	req_t              req_q;
	logic              hit_q;
	attr_t             hit_attr_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [63:0]       rd_key;
	attr_t             rd_attr;
	wr_t               wr;
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] scan_prev;
	logic              rsp_free;
	logic              rsp_load;
	logic              full;
	logic [CNT_W-1:0]  count_next;
	rsp_t              rsp_next;
	attr_t             out_attr;
	logic              is_add;

	assign wr_slot   = (newest_q == LAST_SLOT) ? '0 : newest_q + SLOT_W'(1);
	assign scan_prev = (scan_slot_q == '0) ? LAST_SLOT : scan_slot_q - SLOT_W'(1);
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign rsp_load  = (state_q == S_FIN) && rsp_free;
	assign full      = (count_q == FULL_COUNT);
	assign is_add    = (req_q.req_type == REQ_ADD);

	assign wr.en   = (state_q == S_FIN) && rsp_free && is_add && !hit_q;
	assign wr.key  = req_q.prefix_key;
	assign wr.attr = req_to_attr(req_q);

	always_comb begin
		count_next = count_q;
		out_attr   = '0;
		rsp_next   = '0;
		if (is_add) begin
			if (hit_q) begin
				rsp_next.status = ST_DUPLICATE;
			end else begin
				rsp_next.status  = ST_ADDED;
				rsp_next.evicted = full;
				out_attr         = req_to_attr(req_q);
				if (!full) begin
					count_next = count_q + CNT_W'(1);
				end
			end
		end else begin
			if (hit_q) begin
				rsp_next.status = ST_FOUND;
				out_attr        = hit_attr_q;
			end else begin
				rsp_next.status = ST_NOT_FOUND;
			end
		end
		rsp_next.entry_count_out     = PTE_COUNT_OUT_W'(count_next);
		rsp_next.found_dom_id        = out_attr.dom_id;
		rsp_next.found_border_router = out_attr.border_router;
		rsp_next.found_stable        = out_attr.stable;
		rsp_next.found_auto_pref     = out_attr.auto_pref;
		rsp_next.found_auto_valid    = out_attr.auto_valid;
		rsp_next.found_dhcp          = out_attr.dhcp;
		rsp_next.found_configure     = out_attr.configure;
		rsp_next.found_default_route = out_attr.default_route;
		rsp_next.found_preference    = out_attr.preference;
	end

	pte_store #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.SLOT_W(SLOT_W)
	) u_store (
		.clk(clk),
		.wr(wr),
		.wr_addr(wr_slot),
		.rd_addr(scan_slot_q),
		.rd_key(rd_key),
		.rd_attr(rd_attr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			newest_q    <= '0;
			count_q     <= '0;
			scan_slot_q <= '0;
			left_q      <= '0;
			vld_s1      <= 1'b0;
			req_q       <= '0;
			hit_q       <= 1'b0;
			hit_attr_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (req.valid) begin
						req_q       <= req.data;
						scan_slot_q <= newest_q;
						left_q      <= count_q;
						hit_q       <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (left_q != '0) begin
						vld_s1      <= 1'b1;
						left_q      <= left_q - CNT_W'(1);
						scan_slot_q <= scan_prev;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && rd_key == req_q.prefix_key) begin
						hit_q      <= 1'b1;
						hit_attr_q <= rd_attr;
						state_q    <= S_FIN;
					end else if (left_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					vld_s1 <= 1'b0;
					if (rsp_free) begin
						rsp_q   <= rsp_next;
						count_q <= count_next;
						if (wr.en) begin
							newest_q <= wr_slot;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	`PTE_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_COUNT,
		"entry count exceeds table size")
	`PTE_ASSERT_SAME(a_evict_full, clk, arst_n, rsp.valid && rsp.data.evicted,
		rsp.data.status == ST_ADDED &&
		rsp.data.entry_count_out == PTE_COUNT_OUT_W'(TABLE_ENTRIES),
		"eviction reported without a full table add")
	`PTE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready,
		!req.ready, "request accepted while a scan was starting")

endmodule

>>> sim/prefix_table_fifo_evict_unit_tb.sv
`timescale 1ns / 1ps

module prefix_table_fifo_evict_unit_tb;
	import pte_pkg::*;

	localparam int TBL = PTE_TABLE_ENTRIES;
	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS = 150;
	localparam int PAUSE_AT = 400;
	localparam int POOL_KEYS = 12;
	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		req_t r;
		bit   given;
		rsp_t value;
	} step_t;

	typedef struct {
		bit   given;
		rsp_t value;
	} given_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pte_req_if req_ch ();
	pte_rsp_if rsp_ch ();

	prefix_table_fifo_evict_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	req_t        slot_req [TBL];
	int          newest;
	int          held;
	rsp_t        expect_q [$];
	given_t      given_q [$];
	step_t       steps [$];
	logic [63:0] key_pool [POOL_KEYS];
	int          errors = 0;
	int          quiet = 0;
	bit          calm;
	int          n_added, n_dup, n_found, n_missed, n_evicted, n_checked;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		errors++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	function automatic req_t mk_req(req_kind_t kind, logic [63:0] key, logic [7:0] dom,
			logic [15:0] br, logic [6:0] flags);
		req_t r;
		r.req_type = kind;
		r.prefix_key = key;
		r.dom_id = dom;
		r.border_router = br;
		{r.stable, r.auto_pref, r.auto_valid, r.dhcp, r.configure, r.default_route,
			r.preference} = flags;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(status_t st, logic ev, int cnt, logic [7:0] dom,
			logic [15:0] br, logic [6:0] flags);
		rsp_t o;
		o.status = st;
		o.evicted = ev;
		o.entry_count_out = cnt[PTE_COUNT_OUT_W-1:0];
		o.found_dom_id = dom;
		o.found_border_router = br;
		{o.found_stable, o.found_auto_pref, o.found_auto_valid, o.found_dhcp,
			o.found_configure, o.found_default_route, o.found_preference} = flags;
		return o;
	endfunction

	// Applies one request to the shadow table and returns the result it should produce.
	function automatic rsp_t table_apply(req_t r);
		int   hit;
		int   age;
		int   slot;
		req_t src;
		rsp_t o;
		hit = -1;
		o = '0;
		for (int s = 0; s < TBL; s++) begin
			age = (newest + TBL - s) % TBL;
			if (hit < 0 && age < held && slot_req[s].prefix_key == r.prefix_key) begin
				hit = s;
			end
		end
		src = r;
		if (r.req_type == REQ_ADD) begin
			if (hit >= 0) begin
				o.status = ST_DUPLICATE;
			end else begin
				slot = (newest + 1) % TBL;
				if (held >= TBL) begin
					o.evicted = 1'b1;
					held = TBL - 1;
				end
				slot_req[slot] = r;
				newest = slot;
				held++;
				o.status = ST_ADDED;
			end
		end else if (hit >= 0) begin
			o.status = ST_FOUND;
			src = slot_req[hit];
		end else begin
			o.status = ST_NOT_FOUND;
		end
		if (o.status == ST_ADDED || o.status == ST_FOUND) begin
			o.found_dom_id = src.dom_id;
			o.found_border_router = src.border_router;
			o.found_stable = src.stable;
			o.found_auto_pref = src.auto_pref;
			o.found_auto_valid = src.auto_valid;
			o.found_dhcp = src.dhcp;
			o.found_configure = src.configure;
			o.found_default_route = src.default_route;
			o.found_preference = src.preference;
		end
		o.entry_count_out = held[PTE_COUNT_OUT_W-1:0];
		return o;
	endfunction

	function automatic req_t random_req();
		logic [63:0] key;
		logic [6:0]  flags;
		req_kind_t   kind;
		kind = ($urandom_range(0, 99) < 55) ? REQ_ADD : REQ_LOOKUP;
		if ($urandom_range(0, 99) < 85) begin
			key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
		end else begin
			key = {$urandom, $urandom};
		end
		flags = 7'($urandom);
		return mk_req(kind, key, 8'($urandom), 16'($urandom), flags);
	endfunction

	always @(posedge clk) begin
		rsp_t   got;
		rsp_t   want;
		rsp_t   pred;
		given_t g;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (expect_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: 0x%0h", got));
				end else begin
					want = expect_q.pop_front();
					n_checked++;
					case (want.status)
						ST_ADDED: n_added++;
						ST_DUPLICATE: n_dup++;
						ST_FOUND: n_found++;
						default: n_missed++;
					endcase
					if (want.evicted) begin
						n_evicted++;
					end
					check_field("status", 64'(got.status), 64'(want.status));
					check_field("evicted", 64'(got.evicted), 64'(want.evicted));
					check_field("entry_count_out", 64'(got.entry_count_out),
						64'(want.entry_count_out));
					check_field("found_dom_id", 64'(got.found_dom_id),
						64'(want.found_dom_id));
					check_field("found_border_router", 64'(got.found_border_router),
						64'(want.found_border_router));
					check_field("found_stable", 64'(got.found_stable),
						64'(want.found_stable));
					check_field("found_auto_pref", 64'(got.found_auto_pref),
						64'(want.found_auto_pref));
					check_field("found_auto_valid", 64'(got.found_auto_valid),
						64'(want.found_auto_valid));
					check_field("found_dhcp", 64'(got.found_dhcp), 64'(want.found_dhcp));
					check_field("found_configure", 64'(got.found_configure),
						64'(want.found_configure));
					check_field("found_default_route", 64'(got.found_default_route),
						64'(want.found_default_route));
					check_field("found_preference", 64'(got.found_preference),
						64'(want.found_preference));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				pred = table_apply(req_ch.data);
				g = given_q.pop_front();
				expect_q.push_back(g.given ? g.value : pred);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no beat on either channel for %0d cycles", quiet);
				$display("prefix_table_fifo_evict_unit_tb: FAIL");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		int hold;
		bit stall_on;
		hold = 0;
		stall_on = 1'b1;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0) begin
				stall_on = !stall_on;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (arst_n && !calm && stall_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 8);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_req(req_t r, bit given, rsp_t value);
		given_q.push_back('{given, value});
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic idle_gap(bit idle_on);
		if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	initial begin
		logic [63:0] ones;
		bit          idle_on;
		rsp_t        none;
		ones = '1;
		none = '0;
		calm = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};

		steps.push_back('{mk_req(REQ_LOOKUP, 64'h0, 8'h0, 16'h0, 7'h0), 1'b1,
			mk_rsp(ST_NOT_FOUND, 1'b0, 0, 8'h0, 16'h0, 7'h0)});
		steps.push_back('{mk_req(REQ_ADD, 64'h0, 8'h0, 16'h0, 7'h0), 1'b1,
			mk_rsp(ST_ADDED, 1'b0, 1, 8'h0, 16'h0, 7'h0)});
		steps.push_back('{mk_req(REQ_ADD, ones, 8'hFF, 16'hFFFF, 7'h7F), 1'b1,
			mk_rsp(ST_ADDED, 1'b0, 2, 8'hFF, 16'hFFFF, 7'h7F)});
		steps.push_back('{mk_req(REQ_ADD, 64'h0, 8'h3C, 16'h1234, 7'h2A), 1'b1,
			mk_rsp(ST_DUPLICATE, 1'b0, 2, 8'h0, 16'h0, 7'h0)});
		steps.push_back('{mk_req(REQ_LOOKUP, ones, 8'h0, 16'h0, 7'h0), 1'b1,
			mk_rsp(ST_FOUND, 1'b0, 2, 8'hFF, 16'hFFFF, 7'h7F)});
		steps.push_back('{mk_req(REQ_LOOKUP, 64'h0, 8'hFF, 16'hFFFF, 7'h7F), 1'b1,
			mk_rsp(ST_FOUND, 1'b0, 2, 8'h0, 16'h0, 7'h0)});
		steps.push_back('{mk_req(REQ_LOOKUP, 64'h1, 8'h0, 16'h0, 7'h0), 1'b1,
			mk_rsp(ST_NOT_FOUND, 1'b0, 2, 8'h0, 16'h0, 7'h0)});
		for (int i = 1; i <= 6; i++) begin
			steps.push_back('{mk_req(REQ_ADD, 64'h0123_4567_89AB_CD00 + i, 8'(i * 37),
				16'(i * 4099), 7'(i * 19)), 1'b0, none});
		end
		steps.push_back('{mk_req(REQ_ADD, 64'h8000_0000_0000_0000, 8'h5A, 16'hA5C3, 7'h55), 1'b1,
			mk_rsp(ST_ADDED, 1'b1, TBL, 8'h5A, 16'hA5C3, 7'h55)});
		steps.push_back('{mk_req(REQ_LOOKUP, 64'h0, 8'h0, 16'h0, 7'h0), 1'b1,
			mk_rsp(ST_NOT_FOUND, 1'b0, TBL, 8'h0, 16'h0, 7'h0)});
		steps.push_back('{mk_req(REQ_LOOKUP, 64'h0123_4567_89AB_CD03, 8'h11, 16'h2222, 7'h33),
			1'b0, none});
		steps.push_back('{mk_req(REQ_ADD, ones, 8'h00, 16'h0000, 7'h00), 1'b1,
			mk_rsp(ST_DUPLICATE, 1'b0, TBL, 8'h0, 16'h0, 7'h0)});
		steps.push_back('{mk_req(REQ_ADD, 64'h1, 8'hA5, 16'h5AA5, 7'h2A), 1'b1,
			mk_rsp(ST_ADDED, 1'b1, TBL, 8'hA5, 16'h5AA5, 7'h2A)});
		steps.push_back('{mk_req(REQ_LOOKUP, ones, 8'h0, 16'h0, 7'h0), 1'b1,
			mk_rsp(ST_NOT_FOUND, 1'b0, TBL, 8'h0, 16'h0, 7'h0)});
		steps.push_back('{mk_req(REQ_LOOKUP, 64'h1, 8'h0, 16'h0, 7'h0), 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			send_req(steps[i].r, steps[i].given, steps[i].value);
			idle_gap(1'b1);
		end

		idle_on = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				idle_on = ($urandom_range(0, 2) != 0);
			end
			if (i == RANDOM_ITEMS - CALM_ITEMS) begin
				calm = 1'b1;
			end
			if (i == PAUSE_AT) begin
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (expect_q.size() != 0);
			end
			send_req(random_req(), 1'b0, none);
			idle_gap(idle_on);
		end

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expect_q.size() != 0);
		repeat (TBL + 8) @(posedge clk);

		$display("Checked %0d results: %0d added, %0d duplicates, %0d found, %0d not found.",
			n_checked, n_added, n_dup, n_found, n_missed);
		$display("Adds that evicted the oldest entry: %0d; mismatches: %0d.", n_evicted, errors);
		if (errors == 0) begin
			$display("prefix_table_fifo_evict_unit_tb: PASS");
		end else begin
			$display("prefix_table_fifo_evict_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
